/* sv/shape_bounding_box_assert.svh */
// ----------------------------------------------------------------------------
// Shape bounding box assertion macros
// Clocked implication checks shared by the shape bounding box RTL.
// ----------------------------------------------------------------------------
`ifndef SHAPE_BOUNDING_BOX_ASSERT_SVH
`define SHAPE_BOUNDING_BOX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shape bounding box check failed");

// Next-cycle implication, disabled during reset.
`define SBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shape bounding box check failed");

`endif

/* sv/sbb_pkg.sv */
// ----------------------------------------------------------------------------
// Shape bounding box package
// Types, widths and helpers shared by the bounding box pipeline.
// ----------------------------------------------------------------------------
package sbb_pkg;

    typedef enum logic [1:0] {
        KindSphere    = 2'd0,
        KindBox       = 2'd1,
        KindPlane     = 2'd2,
        KindUndefined = 2'd3
    } shape_kind_t;

    localparam int MatW  = 36;
    localparam int AbsW  = 24;
    localparam int ProdW = 55;
    localparam int ExtW  = 41;
    localparam int SumW  = 43;
    localparam int Stages = 6;

    localparam logic signed [MatW-1:0] Q28One = 36'sh010000000;
    localparam logic [20:0] NormalLimitX10 = 21'd147456;
    localparam logic signed [SumW-1:0] SlabHalf = 43'sd41;
    localparam logic signed [SumW-1:0] SatMax = {{(SumW-32){1'b0}}, 32'h7fffffff};
    localparam logic signed [SumW-1:0] SatMin = {{(SumW-32){1'b1}}, 32'h80000000};

    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
    } prod_t;

    typedef logic [8:0][AbsW-1:0] abs_vec_t;

    function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
        logic signed [31:0] r;
        if (v > SatMax) r = 32'sh7fffffff;
        else if (v < SatMin) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

/* sv/sbb_shape_if.sv */
// ----------------------------------------------------------------------------
// Shape request interface
// Valid/ready channel carrying one shape description.
// ----------------------------------------------------------------------------
interface sbb_shape_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  shape_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic        [30:0] extent_x;
    logic        [30:0] extent_y;
    logic        [30:0] extent_z;
    logic signed [15:0] plane_normal_y;

    modport source(output valid, shape_kind, pos_x, pos_y, pos_z, quat_w, quat_x,
                   quat_y, quat_z, extent_x, extent_y, extent_z, plane_normal_y,
                   input ready);
    modport sink(input valid, shape_kind, pos_x, pos_y, pos_z, quat_w, quat_x,
                 quat_y, quat_z, extent_x, extent_y, extent_z, plane_normal_y,
                 output ready);
endinterface

/* sv/sbb_box_if.sv */
// ----------------------------------------------------------------------------
// Bounding box result interface
// Valid/ready channel carrying the tight and fat boxes.
// ----------------------------------------------------------------------------
interface sbb_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic signed [31:0] fat_min_x;
    logic signed [31:0] fat_min_y;
    logic signed [31:0] fat_min_z;
    logic signed [31:0] fat_max_x;
    logic signed [31:0] fat_max_y;
    logic signed [31:0] fat_max_z;

    modport source(output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                   fat_min_x, fat_min_y, fat_min_z, fat_max_x, fat_max_y, fat_max_z,
                   input ready);
    modport sink(input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                 fat_min_x, fat_min_y, fat_min_z, fat_max_x, fat_max_y, fat_max_z,
                 output ready);
endinterface

/* sv/sbb_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel carrying the fat margin register value.
// ----------------------------------------------------------------------------
interface sbb_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] fat_margin;

    modport source(output valid, fat_margin, input ready);
    modport sink(input valid, fat_margin, output ready);
endinterface

/* sv/sbb_abs_rot.sv */
// ----------------------------------------------------------------------------
// Absolute rotation matrix
// Forms the quaternion rotation matrix in Q.28 and rounds each magnitude to Q.16.
// ----------------------------------------------------------------------------
module sbb_abs_rot (
    input  sbb_pkg::prod_t    p,
    output sbb_pkg::abs_vec_t a
);

    logic signed [sbb_pkg::MatW-1:0] m [9];
    logic        [sbb_pkg::MatW-1:0] mag [9];
    logic        [sbb_pkg::MatW-1:0] rnd [9];

    always_comb
    begin
        m[0] = sbb_pkg::Q28One
             - ((sbb_pkg::MatW'(p.yy) + sbb_pkg::MatW'(p.zz)) <<< 1);
        m[1] = (sbb_pkg::MatW'(p.xy) - sbb_pkg::MatW'(p.wz)) <<< 1;
        m[2] = (sbb_pkg::MatW'(p.xz) + sbb_pkg::MatW'(p.wy)) <<< 1;
        m[3] = (sbb_pkg::MatW'(p.xy) + sbb_pkg::MatW'(p.wz)) <<< 1;
        m[4] = sbb_pkg::Q28One
             - ((sbb_pkg::MatW'(p.xx) + sbb_pkg::MatW'(p.zz)) <<< 1);
        m[5] = (sbb_pkg::MatW'(p.yz) - sbb_pkg::MatW'(p.wx)) <<< 1;
        m[6] = (sbb_pkg::MatW'(p.xz) - sbb_pkg::MatW'(p.wy)) <<< 1;
        m[7] = (sbb_pkg::MatW'(p.yz) + sbb_pkg::MatW'(p.wx)) <<< 1;
        m[8] = sbb_pkg::Q28One
             - ((sbb_pkg::MatW'(p.xx) + sbb_pkg::MatW'(p.yy)) <<< 1);
        for (int i = 0; i < 9; i++)
        begin
            mag[i] = m[i][sbb_pkg::MatW-1] ? sbb_pkg::MatW'(-m[i]) : sbb_pkg::MatW'(m[i]);
            rnd[i] = mag[i] + sbb_pkg::MatW'(2048);
            a[i]   = rnd[i][12 +: sbb_pkg::AbsW];
        end
    end

endmodule

/* sv/shape_bounding_box.sv */
// The result is valid on bbox once the accepted shape request has passed six
// register stages, Stage 0 to Stage 5, in order.
// Throughput: one request per cycle while bbox.ready is high; each stage holds
// one request and advances whenever the stage after it is empty or moving.
// Reset clears every stage valid bit and sets the fat margin to zero.
// ----------------------------------------------------------------------------
// Shape bounding box
// Six-stage pipeline turning sphere, box and plane shapes into tight and fat
// axis-aligned bounding boxes.
// ----------------------------------------------------------------------------
`include "shape_bounding_box_assert.svh"

module shape_bounding_box (
    input  logic      clk,
    input  logic      rst_n,
    sbb_cfg_if.sink   cfg,
    sbb_shape_if.sink shape,
    sbb_box_if.source bbox
);

    localparam int N = sbb_pkg::Stages;

    logic [19:0]  margin_reg;
    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    // Stage 0: quaternion products and plane normal test.
    sbb_pkg::shape_kind_t kind0_reg;
    logic                 zero0_reg;
    logic signed [31:0]   pos0_reg [3];
    logic        [30:0]   ext0_reg [3];
    sbb_pkg::prod_t       prod0_reg;
    logic                 vert0_reg;

    // Stage 1: rounded absolute matrix.
    sbb_pkg::shape_kind_t kind1_reg;
    logic                 zero1_reg;
    logic signed [31:0]   pos1_reg [3];
    logic        [30:0]   ext1_reg [3];
    sbb_pkg::abs_vec_t    abs1_reg;
    logic                 vert1_reg;

    // Stage 2: entry times extent products.
    sbb_pkg::shape_kind_t   kind2_reg;
    logic                   zero2_reg;
    logic signed [31:0]     pos2_reg [3];
    logic        [30:0]     rad2_reg;
    logic [sbb_pkg::ProdW-1:0] prd2_reg [9];
    logic                   vert2_reg;

    // Stage 3: world half extents.
    sbb_pkg::shape_kind_t   kind3_reg;
    logic                   zero3_reg;
    logic signed [31:0]     pos3_reg [3];
    logic        [30:0]     rad3_reg;
    logic [sbb_pkg::ExtW-1:0] wext3_reg [3];
    logic                   vert3_reg;

    // Stage 4: tight box.
    logic                 zero4_reg;
    logic signed [31:0]   lo4_reg [3];
    logic signed [31:0]   hi4_reg [3];

    // Stage 5: output register with fat box.
    logic                 zero5_reg;
    logic signed [31:0]   lo5_reg [3];
    logic signed [31:0]   hi5_reg [3];
    logic signed [31:0]   flo5_reg [3];
    logic signed [31:0]   fhi5_reg [3];

    logic signed [16:0] ny_s;
    logic        [16:0] ny_abs;
    logic        [20:0] ny_x10;
    sbb_pkg::abs_vec_t  abs_next;
    logic signed [31:0] lo_next [3];
    logic signed [31:0] hi_next [3];
    logic [sbb_pkg::ProdW+1:0] sum_next [3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= '0;
        end
        else if (cfg.valid)
        begin
            margin_reg <= cfg.fat_margin;
        end
    end

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || bbox.ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign shape.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= shape.valid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        ny_s   = 17'(shape.plane_normal_y);
        ny_abs = ny_s[16] ? 17'(-ny_s) : 17'(ny_s);
        ny_x10 = 21'(ny_abs) * 21'd10;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero0_reg    <= (shape.shape_kind == sbb_pkg::KindUndefined);
            kind0_reg    <= sbb_pkg::shape_kind_t'(shape.shape_kind);
            pos0_reg[0]  <= shape.pos_x;
            pos0_reg[1]  <= shape.pos_y;
            pos0_reg[2]  <= shape.pos_z;
            ext0_reg[0]  <= shape.extent_x;
            ext0_reg[1]  <= shape.extent_y;
            ext0_reg[2]  <= shape.extent_z;
            prod0_reg.xx <= 32'(shape.quat_x) * 32'(shape.quat_x);
            prod0_reg.yy <= 32'(shape.quat_y) * 32'(shape.quat_y);
            prod0_reg.zz <= 32'(shape.quat_z) * 32'(shape.quat_z);
            prod0_reg.xy <= 32'(shape.quat_x) * 32'(shape.quat_y);
            prod0_reg.xz <= 32'(shape.quat_x) * 32'(shape.quat_z);
            prod0_reg.yz <= 32'(shape.quat_y) * 32'(shape.quat_z);
            prod0_reg.wx <= 32'(shape.quat_w) * 32'(shape.quat_x);
            prod0_reg.wy <= 32'(shape.quat_w) * 32'(shape.quat_y);
            prod0_reg.wz <= 32'(shape.quat_w) * 32'(shape.quat_z);
            vert0_reg    <= ny_x10 > sbb_pkg::NormalLimitX10;
        end
    end

    sbb_abs_rot u_abs_rot (
        .p (prod0_reg),
        .a (abs_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            zero1_reg <= zero0_reg;
            kind1_reg <= kind0_reg;
            pos1_reg  <= pos0_reg;
            ext1_reg  <= ext0_reg;
            abs1_reg  <= abs_next;
            vert1_reg <= vert0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            zero2_reg <= zero1_reg;
            kind2_reg <= kind1_reg;
            pos2_reg  <= pos1_reg;
            rad2_reg  <= ext1_reg[0];
            vert2_reg <= vert1_reg;
            for (int i = 0; i < 9; i++)
            begin
                prd2_reg[i] <= sbb_pkg::ProdW'(abs1_reg[i])
                             * sbb_pkg::ProdW'(ext1_reg[i % 3]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = (sbb_pkg::ProdW + 2)'(prd2_reg[3*r])
                        + (sbb_pkg::ProdW + 2)'(prd2_reg[3*r+1])
                        + (sbb_pkg::ProdW + 2)'(prd2_reg[3*r+2])
                        + (sbb_pkg::ProdW + 2)'(32768);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            zero3_reg <= zero2_reg;
            kind3_reg <= kind2_reg;
            pos3_reg  <= pos2_reg;
            rad3_reg  <= rad2_reg;
            vert3_reg <= vert2_reg;
            for (int r = 0; r < 3; r++)
            begin
                wext3_reg[r] <= sum_next[r][16 +: sbb_pkg::ExtW];
            end
        end
    end

    always_comb
    begin
        logic signed [sbb_pkg::SumW-1:0] p;
        logic signed [sbb_pkg::SumW-1:0] d;
        for (int i = 0; i < 3; i++)
        begin
            p = sbb_pkg::SumW'(pos3_reg[i]);
            d = '0;
            case (kind3_reg)
                sbb_pkg::KindSphere: d = $signed({12'b0, rad3_reg});
                sbb_pkg::KindBox:    d = $signed({2'b0, wext3_reg[i]});
                default:             d = sbb_pkg::SlabHalf;
            endcase
            lo_next[i] = sbb_pkg::sat32(p - d);
            hi_next[i] = sbb_pkg::sat32(p + d);
            if (kind3_reg == sbb_pkg::KindPlane && !(i == 1 && vert3_reg))
            begin
                lo_next[i] = 32'sh80000000;
                hi_next[i] = 32'sh7fffffff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            zero4_reg <= zero3_reg;
            lo4_reg   <= lo_next;
            hi4_reg   <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            zero5_reg <= zero4_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (zero4_reg)
                begin
                    lo5_reg[i]  <= '0;
                    hi5_reg[i]  <= '0;
                    flo5_reg[i] <= '0;
                    fhi5_reg[i] <= '0;
                end
                else
                begin
                    lo5_reg[i]  <= lo4_reg[i];
                    hi5_reg[i]  <= hi4_reg[i];
                    flo5_reg[i] <= sbb_pkg::sat32(sbb_pkg::SumW'(lo4_reg[i])
                                 - $signed({{(sbb_pkg::SumW-20){1'b0}}, margin_reg}));
                    fhi5_reg[i] <= sbb_pkg::sat32(sbb_pkg::SumW'(hi4_reg[i])
                                 + $signed({{(sbb_pkg::SumW-20){1'b0}}, margin_reg}));
                end
            end
        end
    end

    assign bbox.valid     = v_reg[N-1];
    assign bbox.min_x     = lo5_reg[0];
    assign bbox.min_y     = lo5_reg[1];
    assign bbox.min_z     = lo5_reg[2];
    assign bbox.max_x     = hi5_reg[0];
    assign bbox.max_y     = hi5_reg[1];
    assign bbox.max_z     = hi5_reg[2];
    assign bbox.fat_min_x = flo5_reg[0];
    assign bbox.fat_min_y = flo5_reg[1];
    assign bbox.fat_min_z = flo5_reg[2];
    assign bbox.fat_max_x = fhi5_reg[0];
    assign bbox.fat_max_y = fhi5_reg[1];
    assign bbox.fat_max_z = fhi5_reg[2];

    `SBB_ASSERT_IMPL(a_ready_needs_room, bbox.valid && !bbox.ready && shape.ready,
                     v_reg != {N{1'b1}})
    `SBB_ASSERT_IMPL(a_undefined_kind_zero, bbox.valid && zero5_reg,
                     bbox.min_x == 0 && bbox.max_y == 0
                     && bbox.fat_min_z == 0 && bbox.fat_max_x == 0)
    `SBB_ASSERT_IMPL(a_fat_encloses, bbox.valid && !zero5_reg,
                     bbox.fat_min_x <= bbox.min_x && bbox.fat_max_z >= bbox.max_z)
    `SBB_ASSERT_NEXT(a_stall_holds_valid, bbox.valid && !bbox.ready, bbox.valid)

endmodule

/* tb/sbb_tb_if.sv */
// ----------------------------------------------------------------------------
// Shape bounding box testbench constants
// The block's channel interfaces live with the RTL; this file holds the
// constants that only the testbench's predictor needs.
// ----------------------------------------------------------------------------
package sbb_tb_pkg;
    localparam int SlabHalfQ12 = 41;
endpackage

/* tb/tb_shape_bounding_box.sv */
// ----------------------------------------------------------------------------
// Shape bounding box testbench
// Drives spheres, boxes, planes and undefined kinds with random idling on both
// channels, predicts each tight and fat box and checks every result in order.
// ----------------------------------------------------------------------------
module tb_shape_bounding_box;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qw, qx, qy, qz;
        logic [30:0]        hx, hy, hz;
        logic signed [15:0] ny;
    } shape_req_t;

    typedef struct {
        logic signed [31:0] v [12];
    } box_res_t;

    class box_scoreboard;
        logic [19:0] margin;
        box_res_t    pending [$];
        int          errors;

        function new();
            margin = '0;
            errors = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint round_abs(longint e);
            longint a;
            a = (e < 0) ? -e : e;
            return (a + 2048) >>> 12;
        endfunction

        function longint span(longint e0, longint e1, longint e2, longint h0, longint h1,
                              longint h2);
            longint s;
            s = round_abs(e0) * h0 + round_abs(e1) * h1 + round_abs(e2) * h2;
            return (s + 32768) >>> 16;
        endfunction

        function void note_request(shape_req_t r);
            longint   c [3], lo [3], hi [3], e [3];
            longint   w, x, y, z, one, an;
            box_res_t res;
            c[0] = longint'(r.px); c[1] = longint'(r.py); c[2] = longint'(r.pz);
            one = 64'sd1 << 28;
            if (r.kind == sbb_pkg::KindSphere)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lo[i] = clamp32(c[i] - longint'(r.hx));
                    hi[i] = clamp32(c[i] + longint'(r.hx));
                end
            end
            else if (r.kind == sbb_pkg::KindBox)
            begin
                w = longint'(r.qw); x = longint'(r.qx);
                y = longint'(r.qy); z = longint'(r.qz);
                e[0] = span(one - 2 * (y * y + z * z), 2 * (x * y - w * z),
                            2 * (x * z + w * y), longint'(r.hx), longint'(r.hy),
                            longint'(r.hz));
                e[1] = span(2 * (x * y + w * z), one - 2 * (x * x + z * z),
                            2 * (y * z - w * x), longint'(r.hx), longint'(r.hy),
                            longint'(r.hz));
                e[2] = span(2 * (x * z - w * y), 2 * (y * z + w * x),
                            one - 2 * (x * x + y * y), longint'(r.hx), longint'(r.hy),
                            longint'(r.hz));
                for (int i = 0; i < 3; i++)
                begin
                    lo[i] = clamp32(c[i] - e[i]);
                    hi[i] = clamp32(c[i] + e[i]);
                end
            end
            else if (r.kind == sbb_pkg::KindPlane)
            begin
                an = (r.ny < 0) ? -longint'(r.ny) : longint'(r.ny);
                for (int i = 0; i < 3; i++)
                begin
                    lo[i] = -64'sd2147483648;
                    hi[i] = 64'sd2147483647;
                end
                if (an * 10 > 147456)
                begin
                    lo[1] = clamp32(c[1] - longint'(sbb_tb_pkg::SlabHalfQ12));
                    hi[1] = clamp32(c[1] + longint'(sbb_tb_pkg::SlabHalfQ12));
                end
            end
            else
            begin
                for (int i = 0; i < 12; i++)
                    res.v[i] = '0;
                pending.push_back(res);
                return;
            end
            for (int i = 0; i < 3; i++)
            begin
                res.v[i]     = 32'(lo[i]);
                res.v[3 + i] = 32'(hi[i]);
                res.v[6 + i] = 32'(clamp32(lo[i] - longint'(margin)));
                res.v[9 + i] = 32'(clamp32(hi[i] + longint'(margin)));
            end
            pending.push_back(res);
        endfunction

        function void check_result(box_res_t got);
            string    names [12];
            box_res_t exp;
            names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z", "fat_min_x",
                      "fat_min_y", "fat_min_z", "fat_max_x", "fat_max_y", "fat_max_z"};
            if (pending.size() == 0)
            begin
                $error("unexpected result with nothing pending");
                errors++;
                return;
            end
            exp = pending.pop_front();
            for (int i = 0; i < 12; i++)
                if (got.v[i] !== exp.v[i])
                begin
                    $error("%s expected %0d actual %0d", names[i], exp.v[i], got.v[i]);
                    errors++;
                end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sbb_cfg_if   cfg ();
    sbb_shape_if shape ();
    sbb_box_if   bbox ();

    shape_bounding_box i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .shape (shape),
        .bbox  (bbox)
    );

    box_scoreboard sb;
    int            sent;
    int            burst_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        box_res_t got;
        if (rst_n && bbox.valid && bbox.ready)
        begin
            got.v = '{bbox.min_x, bbox.min_y, bbox.min_z, bbox.max_x, bbox.max_y,
                      bbox.max_z, bbox.fat_min_x, bbox.fat_min_y, bbox.fat_min_z,
                      bbox.fat_max_x, bbox.fat_max_y, bbox.fat_max_z};
            sb.check_result(got);
        end
    end

    // The receiver stalls in phases: some free-running, some heavily throttled.
    initial
    begin
        int mode;
        bbox.ready = 1'b0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: bbox.ready <= 1'b1;
                1: bbox.ready <= ($urandom_range(0, 3) != 0);
                default: bbox.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_margin(input logic [19:0] value);
        cfg.valid      <= 1'b1;
        cfg.fat_margin <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.margin = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_shape(input shape_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                shape.valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        shape.valid          <= 1'b1;
        shape.shape_kind     <= r.kind;
        shape.pos_x          <= r.px;
        shape.pos_y          <= r.py;
        shape.pos_z          <= r.pz;
        shape.quat_w         <= r.qw;
        shape.quat_x         <= r.qx;
        shape.quat_y         <= r.qy;
        shape.quat_z         <= r.qz;
        shape.extent_x       <= r.hx;
        shape.extent_y       <= r.hy;
        shape.extent_z       <= r.hz;
        shape.plane_normal_y <= r.ny;
        @(posedge clk);
        while (!shape.ready)
            @(posedge clk);
        sb.note_request(r);
        sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        shape.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 8000000)) - 4000000;
            2: return $urandom_range(0, 1) ? 32'sh7ff00000 + $urandom_range(0, 1048575)
                                           : 32'sh80000000 + $urandom_range(0, 1048575);
            default: return $signed($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic logic [30:0] rand_ext();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(0, 4096000));
            default: return 31'($urandom_range(0, 100000));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_q();
        return $urandom_range(0, 7) == 0 ? 16'($urandom)
                                         : 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic shape_req_t rand_shape();
        shape_req_t r;
        int         k;
        real        a, b, c, d, n;
        k = $urandom_range(0, 19);
        r.kind = (k < 7) ? sbb_pkg::KindSphere : (k < 15) ? sbb_pkg::KindBox
               : (k < 19) ? sbb_pkg::KindPlane : sbb_pkg::KindUndefined;
        r.px = rand_pos(); r.py = rand_pos(); r.pz = rand_pos();
        r.hx = rand_ext(); r.hy = rand_ext(); r.hz = rand_ext();
        r.ny = rand_q();
        if ($urandom_range(0, 3) != 0)
        begin
            a = $signed($urandom_range(0, 2000)) - 1000;
            b = $signed($urandom_range(0, 2000)) - 1000;
            c = $signed($urandom_range(0, 2000)) - 1000;
            d = $signed($urandom_range(0, 2000)) - 1000;
            n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
            r.qw = 16'($rtoi(a / n * 16384.0)); r.qx = 16'($rtoi(b / n * 16384.0));
            r.qy = 16'($rtoi(c / n * 16384.0)); r.qz = 16'($rtoi(d / n * 16384.0));
        end
        else
        begin
            r.qw = rand_q(); r.qx = rand_q(); r.qy = rand_q(); r.qz = rand_q();
        end
        return r;
    endfunction

    initial
    begin
        shape_req_t r;
        logic [19:0] margins [4];
        sb = new();
        sent = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.fat_margin = '0;
        shape.valid = 1'b0;
        r = '{default: '0};
        {shape.shape_kind, shape.pos_x, shape.pos_y, shape.pos_z} = '0;
        {shape.quat_w, shape.quat_x, shape.quat_y, shape.quat_z} = '0;
        {shape.extent_x, shape.extent_y, shape.extent_z, shape.plane_normal_y} = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part with the reset margin of zero.
        r = '{kind: sbb_pkg::KindSphere, px: 32'sh7fffffff, py: 32'sh80000000, pz: 0,
              qw: 0, qx: 0, qy: 0, qz: 0, hx: 31'h7fffffff, hy: 0, hz: 0, ny: 0};
        send_shape(r);
        r.hx = 0;
        send_shape(r);
        r = '{kind: sbb_pkg::KindBox, px: 1000, py: -1000, pz: 0, qw: 16384, qx: 0, qy: 0,
              qz: 0, hx: 31'h7fffffff, hy: 31'h7fffffff, hz: 31'h7fffffff, ny: 0};
        send_shape(r);
        r.qw = -16384; r.hx = 4096; r.hy = 8192; r.hz = 12288;
        send_shape(r);
        r.qw = 11585; r.qz = 11585;
        send_shape(r);
        r.qw = 16384; r.qx = 16384; r.qy = -16384; r.qz = 16384;
        send_shape(r);
        r.qw = 16'sh7fff; r.qx = 16'sh8000; r.qy = 16'sh7fff; r.qz = 16'sh8000;
        r.hx = 31'h7fffffff;
        send_shape(r);
        r = '{kind: sbb_pkg::KindPlane, px: 5, py: 32'sh7fffffe0, pz: 9, qw: 0, qx: 0,
              qy: 0, qz: 0, hx: 0, hy: 0, hz: 0, ny: 14746};
        send_shape(r);
        r.ny = 14745;
        send_shape(r);
        r.ny = -14746; r.py = 32'sh80000010;
        send_shape(r);
        r.ny = 16'sh8000;
        send_shape(r);
        r.ny = 16'sh7fff; r.py = 0;
        send_shape(r);
        r.ny = 0;
        send_shape(r);
        r.kind = sbb_pkg::KindUndefined; r.px = -1; r.hx = 31'h7fffffff;
        send_shape(r);
        drain();

        margins = '{20'hfffff, 20'd0, 20'd4096, 20'h00001};
        for (int phase = 0; phase < 4; phase++)
        begin
            write_margin(phase == 3 ? 20'($urandom) : margins[phase]);
            for (int n = 0; n < 235; n++)
                send_shape(rand_shape());
            drain();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/sbb_pkg.sv
sv/sbb_shape_if.sv
sv/sbb_box_if.sv
sv/sbb_cfg_if.sv
sv/sbb_abs_rot.sv
sv/shape_bounding_box.sv
tb/sbb_tb_if.sv
tb/tb_shape_bounding_box.sv
